### rtl/debounced_mode_panel_assert.svh
// ----------------------------------------------------------------------------
// debounced_mode_panel assertion macros
// Shorthand for clocked implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_MODE_PANEL_ASSERT_SVH
`define DEBOUNCED_MODE_PANEL_ASSERT_SVH

// Same-cycle implication
`define DMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dmp_pkg.sv
// ----------------------------------------------------------------------------
// dmp_pkg
// Shared types, codes and light levels of the debounced mode panel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmp_pkg;

  localparam int unsigned NumButtons = 3;

  // Light levels (12-bit PWM)
  localparam logic [11:0] LvlOff = 12'd0;
  localparam logic [11:0] LvlDim = 12'd800;
  localparam logic [11:0] LvlMed = 12'd1800;
  localparam logic [11:0] LvlOn  = 12'd4095;

  // Register reset values
  localparam logic [15:0] DebounceMsRst    = 16'd20;
  localparam logic [15:0] BlinkPeriodMsRst = 16'd500;
  localparam logic [6:0]  LowBatteryRst    = 7'd20;

  typedef enum logic [1:0] {
    MODE_STD   = 2'd0,
    MODE_CARE  = 2'd1,
    MODE_STAIR = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_BLINK     = 2'd1,
    REG_LOW_BATT  = 2'd2
  } cfg_reg_t;

  // Button indexes
  localparam int unsigned BtnMode  = 0;
  localparam int unsigned BtnStair = 1;
  localparam int unsigned BtnReset = 2;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        mode_button_raw;
    logic        stair_button_raw;
    logic        reset_button_raw;
    logic        battery_known;
    logic [6:0]  battery_percent;
  } tick_t;

  typedef struct packed {
    logic mode;
    logic stair;
    logic reset;
  } btn_ev_t;

  typedef struct packed {
    mode_t       mode;
    logic        stair_confirm;
    logic        reset_request;
    logic [11:0] mode_red;
    logic [11:0] mode_green;
    logic [11:0] mode_blue;
    logic [11:0] stair_green;
    logic [11:0] reset_red;
  } panel_res_t;

endpackage

### rtl/dmp_if.sv
// ----------------------------------------------------------------------------
// dmp tick and panel channels
// Valid/ready channels for input ticks and panel result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dmp_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        mode_button_raw;
  logic        stair_button_raw;
  logic        reset_button_raw;
  logic        battery_known;
  logic [6:0]  battery_percent;

  modport source (
    output valid, now_ms, mode_button_raw, stair_button_raw, reset_button_raw,
           battery_known, battery_percent,
    input  ready
  );
  modport sink (
    input  valid, now_ms, mode_button_raw, stair_button_raw, reset_button_raw,
           battery_known, battery_percent,
    output ready
  );
endinterface

interface dmp_panel_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        stair_confirm;
  logic        reset_request;
  logic [11:0] mode_red;
  logic [11:0] mode_green;
  logic [11:0] mode_blue;
  logic [11:0] stair_green;
  logic [11:0] reset_red;

  modport source (
    output valid, mode, stair_confirm, reset_request, mode_red, mode_green,
           mode_blue, stair_green, reset_red,
    input  ready
  );
  modport sink (
    input  valid, mode, stair_confirm, reset_request, mode_red, mode_green,
           mode_blue, stair_green, reset_red,
    output ready
  );
endinterface

### rtl/dmp_debounce.sv
// ----------------------------------------------------------------------------
// dmp_debounce
// Time-based debounce of one raw button level with rising-edge press event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmp_debounce
  import dmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        raw,
  input  logic [31:0] now_ms,
  input  logic [15:0] debounce_ms,
  output logic        press
);

  logic        stable_level;
  logic        last_raw_level;
  logic [31:0] last_change_time;

  logic        changed;
  logic [31:0] change_time_next;
  logic [31:0] elapsed;
  logic        settled;

  // Restart the hold timer on a raw change, then test the held time
  always_comb begin
    changed          = raw != last_raw_level;
    change_time_next = changed ? now_ms : last_change_time;
    elapsed          = now_ms - change_time_next;
    settled          = elapsed >= {16'd0, debounce_ms};
    press            = settled && raw && !stable_level;
  end

  // Advance debounce state once per processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level     <= 1'b0;
      last_raw_level   <= 1'b0;
      last_change_time <= 32'd0;
    end else if (step) begin
      last_raw_level   <= raw;
      last_change_time <= change_time_next;
      if (settled) begin
        stable_level <= raw;
      end
    end
  end

endmodule

### rtl/dmp_control.sv
// ----------------------------------------------------------------------------
// dmp_control
// Mode sequencing, stair confirm, blink timer and light level selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmp_control
  import dmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  btn_ev_t     ev,
  input  logic [31:0] now_ms,
  input  logic        battery_known,
  input  logic [6:0]  battery_percent,
  input  logic [15:0] blink_interval_ms,
  input  logic [6:0]  amber_pct,
  output panel_res_t  res
);

  mode_t       mode_q;
  logic        confirm_q;
  logic        blink_q;
  logic [31:0] last_blink_time;

  mode_t       mode_next;
  logic        confirm_next;
  logic        request;
  logic        blink_due;
  logic        blink_next;
  logic        low_batt;

  // Apply events in order mode, stair, reset
  always_comb begin
    mode_next    = mode_q;
    confirm_next = confirm_q;
    request      = 1'b0;
    if (ev.mode) begin
      unique case (mode_q)
        MODE_STD:  mode_next = MODE_CARE;
        MODE_CARE: mode_next = MODE_STAIR;
        default:   mode_next = MODE_STD;
      endcase
      confirm_next = 1'b0;
    end
    if (ev.stair && (mode_next == MODE_STAIR)) begin
      confirm_next = 1'b1;
    end
    if (ev.reset) begin
      mode_next    = MODE_STD;
      confirm_next = 1'b0;
      request      = 1'b1;
    end
  end

  // Toggle blink once the period has elapsed (wrapping difference)
  always_comb begin
    blink_due  = (now_ms - last_blink_time) >= {16'd0, blink_interval_ms};
    blink_next = blink_q ^ blink_due;
  end

  // Select light levels from the updated state
  always_comb begin
    low_batt          = battery_known && (battery_percent <= amber_pct);
    res.mode          = mode_next;
    res.stair_confirm = confirm_next;
    res.reset_request = request;
    if (low_batt) begin
      res.mode_red   = LvlMed;
      res.mode_green = LvlMed;
      res.mode_blue  = LvlOff;
    end else begin
      case (mode_next)
        MODE_STD: begin
          res.mode_red   = LvlOff;
          res.mode_green = LvlOn;
          res.mode_blue  = LvlOff;
        end
        MODE_CARE: begin
          res.mode_red   = LvlOff;
          res.mode_green = LvlOff;
          res.mode_blue  = LvlOn;
        end
        default: begin
          res.mode_red   = LvlOn;
          res.mode_green = LvlOn;
          res.mode_blue  = LvlOff;
        end
      endcase
    end
    if (mode_next == MODE_STAIR) begin
      res.stair_green = confirm_next ? (blink_next ? LvlOn : LvlOff) : LvlDim;
    end else begin
      res.stair_green = LvlOff;
    end
    res.reset_red = request ? (blink_next ? LvlOn : LvlOff) : LvlDim;
  end

  // Hold mode, confirm and blink state; advance once per processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q          <= MODE_STD;
      confirm_q       <= 1'b0;
      blink_q         <= 1'b0;
      last_blink_time <= 32'd0;
    end else if (step) begin
      mode_q    <= mode_next;
      confirm_q <= confirm_next;
      blink_q   <= blink_next;
      if (blink_due) begin
        last_blink_time <= now_ms;
      end
    end
  end

endmodule

### rtl/debounced_mode_panel.sv
// Debounced mode panel.
// Ticks arrive on the tick channel (valid/ready): a millisecond time stamp,
// three raw button levels and the battery reading. Each accepted tick yields
// exactly one beat on the panel channel with the mode, stair confirm, reset
// request and five 12-bit light levels.
// Path: an accepted tick is held in the input register, and its result is then
// registered in the result register, which drives the panel beat.
// Throughput: one tick per cycle while the receiver takes every beat; all
// per-tick work is one compare/subtract stage between the two registers.
// Reset (rst, synchronous): both registers empty, buttons released, mode
// Standard, blink flag clear, registers back to 20 ms debounce, 500 ms blink
// period and 20 percent low battery.
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more tick; tick.ready then drops until
// the panel beat is taken.
// Configuration: cfg_we/cfg_index/cfg_data, written while no tick is in flight.
// ----------------------------------------------------------------------------
// debounced_mode_panel
// Top level: channel registers, configuration and per-button debounce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "debounced_mode_panel_assert.svh"

module debounced_mode_panel
  import dmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dmp_tick_if.sink    tick,
  dmp_panel_if.source panel,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] debounce_ms;
  logic [15:0] blink_interval_ms;
  logic [6:0]  amber_pct;

  logic       s1_valid;
  tick_t      s1;
  logic       res_valid;
  panel_res_t res;
  panel_res_t res_next;
  logic       advance;

  logic [NumButtons-1:0] raw;
  logic [NumButtons-1:0] press;
  btn_ev_t               ev;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms       <= DebounceMsRst;
      blink_interval_ms <= BlinkPeriodMsRst;
      amber_pct         <= LowBatteryRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: debounce_ms       <= cfg_data;
        REG_BLINK:    blink_interval_ms <= cfg_data;
        REG_LOW_BATT: amber_pct         <= cfg_data[6:0];
        default:      ;
      endcase
    end
  end

  // Move the held tick into the result register when that register frees up
  assign advance    = s1_valid && (!res_valid || panel.ready);
  assign tick.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (tick.ready) begin
        s1_valid <= tick.valid;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (panel.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1.now_ms           <= tick.now_ms;
      s1.mode_button_raw  <= tick.mode_button_raw;
      s1.stair_button_raw <= tick.stair_button_raw;
      s1.reset_button_raw <= tick.reset_button_raw;
      s1.battery_known    <= tick.battery_known;
      s1.battery_percent  <= tick.battery_percent;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  // Debounce each button
  assign raw[BtnMode]  = s1.mode_button_raw;
  assign raw[BtnStair] = s1.stair_button_raw;
  assign raw[BtnReset] = s1.reset_button_raw;

  for (genvar b = 0; b < NumButtons; b++) begin : g_btn
    dmp_debounce u_debounce (
      .clk         (clk),
      .rst         (rst),
      .step        (advance),
      .raw         (raw[b]),
      .now_ms      (s1.now_ms),
      .debounce_ms (debounce_ms),
      .press       (press[b])
    );
  end

  assign ev.mode  = press[BtnMode];
  assign ev.stair = press[BtnStair];
  assign ev.reset = press[BtnReset];

  dmp_control u_control (
    .clk               (clk),
    .rst               (rst),
    .step              (advance),
    .ev                (ev),
    .now_ms            (s1.now_ms),
    .battery_known     (s1.battery_known),
    .battery_percent   (s1.battery_percent),
    .blink_interval_ms (blink_interval_ms),
    .amber_pct         (amber_pct),
    .res               (res_next)
  );

  // Drive the panel channel from the result register
  assign panel.valid         = res_valid;
  assign panel.mode          = res.mode;
  assign panel.stair_confirm = res.stair_confirm;
  assign panel.reset_request = res.reset_request;
  assign panel.mode_red      = res.mode_red;
  assign panel.mode_green    = res.mode_green;
  assign panel.mode_blue     = res.mode_blue;
  assign panel.stair_green   = res.stair_green;
  assign panel.reset_red     = res.reset_red;

  // Checks
  `DMP_ASSERT_NOW(a_reset_ends_std, res_valid && res.reset_request,
    (res.mode == MODE_STD) && !res.stair_confirm, "reset request outside Standard")
  `DMP_ASSERT_NOW(a_confirm_in_stair, res_valid && res.stair_confirm,
    res.mode == MODE_STAIR, "stair confirm outside StairClimbing")
  `DMP_ASSERT_NOW(a_stair_light_off, res_valid && (res.mode != MODE_STAIR),
    res.stair_green == LvlOff, "stair light lit outside StairClimbing")
  `DMP_ASSERT_NOW(a_full_blocks_input, s1_valid && !advance,
    !tick.ready, "input taken while held tick cannot advance")
  `DMP_ASSERT_NEXT(a_advance_fills_result, advance,
    res_valid, "advanced tick left no result")

endmodule
